@@ hdl/bp_pkg.sv @@
// shared types and constants of the msb-first bit packer
`default_nettype none

package bp_pkg;

  localparam int unsigned CODE_BITS  = 64;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned HOLD_BITS  = BYTE_BITS - 1;
  localparam int unsigned MAX_BYTES  = CODE_BITS / BYTE_BITS;
  localparam int unsigned ALIGN_BITS = CODE_BITS + BYTE_BITS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [6:0]           count_t;
  typedef logic [3:0]           nbytes_t;

  typedef struct packed {
    logic [HOLD_BITS-1:0] bits;
    logic [2:0]           count;
  } hold_t;

  typedef struct packed {
    code_t   bytes;
    nbytes_t nbytes;
    logic    stream_end;
    hold_t   hold;
  } pack_t;

endpackage

`default_nettype wire

@@ hdl/msb_first_bit_packer.sv @@
// top level of the msb-first variable-length bit packer
// flow: an accepted item waits in the input register until the result register is free, then
//   loads into it and its first byte is offered; a write that completes no byte gives none
// result channel: one byte per cycle while out_ready is high; a 64-bit write emits up to 8 bytes,
//   and the input register can hold the next item while the result register still drains
// reset: synchronous active-low rst_n empties both registers and clears the held bits
`default_nettype none

module msb_first_bit_packer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_operation,
  input  wire bp_pkg::code_t  in_code_value,
  input  wire bp_pkg::count_t in_bit_count,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_of_run,
  output logic                out_stream_end
);
  import bp_pkg::*;

  logic   vld_r;
  logic   op_r;
  code_t  val_r;
  count_t cnt_r;
  hold_t  hold_r;
  pack_t  packed_item;
  logic   empty_next;
  logic   load;

  assign load     = vld_r && empty_next;
  assign in_ready = !vld_r || load;

  bp_pack u_pack (
    .operation  (op_r),
    .code_value (val_r),
    .bit_count  (cnt_r),
    .hold       (hold_r),
    .result     (packed_item)
  );

  bp_byte_queue u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .load_data       (packed_item),
    .empty_next      (empty_next),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_stream_end  (out_stream_end)
  );

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= in_operation;
      val_r <= in_code_value;
      cnt_r <= in_bit_count;
    end
    if (!rst_n) begin
      vld_r  <= 1'b0;
      hold_r <= '0;
    end else begin
      if (in_ready) begin
        vld_r <= in_valid;
      end
      if (load) begin
        hold_r <= packed_item.hold;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bp_pack.sv @@
// combinational alignment of held bits and a new code into whole bytes
`default_nettype none

module bp_pack (
  input  wire logic           operation,
  input  wire bp_pkg::code_t  code_value,
  input  wire bp_pkg::count_t bit_count,
  input  wire bp_pkg::hold_t  hold,
  output bp_pkg::pack_t       result
);
  import bp_pkg::*;

  count_t                cnt_sat;
  code_t                 mask;
  code_t                 masked;
  count_t                total;
  logic [ALIGN_BITS-2:0] combined;
  logic [ALIGN_BITS-1:0] aligned;
  logic [7:0]            shift_amt;
  logic [2:0]            rem;
  logic [7:0]            rem_mask;
  logic [3:0]            pad;
  logic [15:0]           flush_word;

  always_comb begin
    cnt_sat    = (bit_count > count_t'(CODE_BITS)) ? count_t'(CODE_BITS) : bit_count;
    mask       = (cnt_sat == count_t'(CODE_BITS)) ? '1 : ((code_t'(1) << cnt_sat) - code_t'(1));
    masked     = code_value & mask;
    total      = count_t'({4'd0, hold.count}) + cnt_sat;
    combined   = ((ALIGN_BITS-1)'(hold.bits) << cnt_sat) | (ALIGN_BITS-1)'(masked);
    shift_amt  = 8'(ALIGN_BITS) - {1'b0, total};
    aligned    = {1'b0, combined} << shift_amt;
    rem        = total[2:0];
    rem_mask   = (8'd1 << rem) - 8'd1;
    pad        = 4'(BYTE_BITS) - {1'b0, hold.count};
    flush_word = (16'(hold.bits) << pad) | ((16'd1 << pad) - 16'd1);

    if (operation == OP_FLUSH) begin
      result.bytes      = {flush_word[7:0], {(CODE_BITS-BYTE_BITS){1'b0}}};
      result.nbytes     = nbytes_t'(1);
      result.stream_end = 1'b1;
      result.hold       = '0;
    end else begin
      result.bytes      = aligned[ALIGN_BITS-1:BYTE_BITS];
      result.nbytes     = total[6:3];
      result.stream_end = 1'b0;
      result.hold.bits  = combined[HOLD_BITS-1:0] & rem_mask[HOLD_BITS-1:0];
      result.hold.count = rem;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bp_byte_queue.sv @@
// result register that hands out the bytes of one item one per cycle while out_ready is high
`default_nettype none

module bp_byte_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire bp_pkg::pack_t load_data,
  output logic               empty_next,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_stream_end
);
  import bp_pkg::*;

  code_t   bytes_r, bytes_nxt;
  nbytes_t count_r, count_nxt;
  logic    end_r, end_nxt;
  logic    pop;

  assign out_valid       = (count_r != '0);
  assign pop             = out_valid && out_ready;
  assign empty_next      = (count_r == '0) || (count_r == nbytes_t'(1) && pop);
  assign out_byte        = bytes_r[CODE_BITS-1 -: BYTE_BITS];
  assign out_last_of_run = (count_r == nbytes_t'(1));
  assign out_stream_end  = end_r;

  always_comb begin
    bytes_nxt = bytes_r;
    count_nxt = count_r;
    end_nxt   = end_r;
    if (load) begin
      bytes_nxt = load_data.bytes;
      count_nxt = load_data.nbytes;
      end_nxt   = load_data.stream_end;
    end else if (pop) begin
      bytes_nxt = bytes_r << BYTE_BITS;
      count_nxt = count_r - nbytes_t'(1);
      end_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (!rst_n) begin
      count_r <= '0;
      end_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      end_r   <= end_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nbytes_t'(MAX_BYTES))
    else $error("byte count out of range");

  a_end_single: assert property (@(posedge clk) disable iff (!rst_n)
    end_r |-> (count_r == nbytes_t'(1)))
    else $error("stream end flag on a multi-byte run");

  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && count_r > nbytes_t'(1)) |=> (count_r == $past(count_r) - nbytes_t'(1)))
    else $error("byte count did not step down");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> empty_next)
    else $error("load over undelivered bytes");

endmodule

`default_nettype wire
